// ===== src/jse_pkg.sv =====
// Package with the shared types, character codes and helpers of the JSON string escaper.
package jse_pkg;

  localparam int unsigned CharBitsDefault = 16;
  localparam int unsigned QueueDepth      = 4;
  localparam int unsigned NumSlots        = 8;

  localparam logic [15:0] CH_QUOTE  = 16'h0022;
  localparam logic [15:0] CH_BSLASH = 16'h005C;
  localparam logic [15:0] CH_U      = 16'h0075;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        first_of_string;
    logic        last_of_string;
    logic        empty_string;
  } in_item_t;

  typedef struct packed {
    logic [15:0] out_char;
    logic        run_end;
  } out_item_t;

  // Body shape of one item, decided by the front end.
  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_PASS,
    KIND_SHORT,
    KIND_UNI
  } kind_e;

  typedef struct packed {
    kind_e kind;
    logic  quote_before;
    logic  quote_after;
  } desc_t;

  function automatic logic [15:0] hex_char(input logic [3:0] nib);
    logic [15:0] ch;
    if (nib < 4'd10) begin
      ch = 16'h0030 + 16'(nib);
    end else begin
      ch = 16'h0037 + 16'(nib);
    end
    return ch;
  endfunction

endpackage

// ===== src/jse_front.sv =====
// Front end: holds the quoting register and classifies each accepted code unit.
module jse_front #(
  parameter int unsigned CHAR_BITS = jse_pkg::CharBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i,
  input  logic                 accept_i,
  input  jse_pkg::in_item_t    item_i,
  output logic                 enq_o,
  output jse_pkg::desc_t       desc_o,
  output logic [CHAR_BITS-1:0] unit_o
);
  import jse_pkg::*;

  logic                 add_quotes_q;
  logic [CHAR_BITS-1:0] unit;
  logic [15:0]          unit_w;
  logic [7:0]           letter;
  logic                 is_short;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      add_quotes_q <= 1'b1;
    end else if (cfg_we_i) begin
      add_quotes_q <= cfg_wdata_i;
    end
  end

  assign unit   = item_i.code_unit[CHAR_BITS-1:0];
  assign unit_w = 16'(unit);

  always_comb begin
    is_short = 1'b1;
    letter   = 8'h00;
    case (unit_w)
      16'h0022: letter = 8'h22;
      16'h005C: letter = 8'h5C;
      16'h002F: letter = 8'h2F;
      16'h0008: letter = 8'h62;
      16'h000C: letter = 8'h66;
      16'h000A: letter = 8'h6E;
      16'h000D: letter = 8'h72;
      16'h0009: letter = 8'h74;
      default:  is_short = 1'b0;
    endcase
  end

  always_comb begin
    desc_o = '{kind: KIND_PASS, quote_before: 1'b0, quote_after: 1'b0};
    unit_o = unit;
    if (item_i.empty_string) begin
      desc_o.kind         = KIND_NONE;
      desc_o.quote_before = add_quotes_q;
      desc_o.quote_after  = add_quotes_q;
    end else begin
      desc_o.quote_before = add_quotes_q & item_i.first_of_string;
      desc_o.quote_after  = add_quotes_q & item_i.last_of_string;
      if (is_short) begin
        desc_o.kind = KIND_SHORT;
        unit_o      = CHAR_BITS'(letter);
      end else if (unit_w < 16'h0020 || unit_w > 16'h00FF) begin
        desc_o.kind = KIND_UNI;
      end
    end
  end

  // An empty string without quoting produces nothing and is dropped here.
  assign enq_o = accept_i & (desc_o.kind != KIND_NONE || desc_o.quote_before);

endmodule

// ===== src/jse_queue.sv =====
// Small FIFO of classified items between the front end and the output sequencer.
module jse_queue #(
  parameter int unsigned CHAR_BITS = jse_pkg::CharBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 enq_i,
  input  jse_pkg::desc_t       desc_i,
  input  logic [CHAR_BITS-1:0] unit_i,
  input  logic                 deq_i,
  output logic                 full_o,
  output logic                 head_valid_o,
  output jse_pkg::desc_t       head_desc_o,
  output logic [CHAR_BITS-1:0] head_unit_o
);
  import jse_pkg::*;

  localparam int unsigned PtrBits = $clog2(QueueDepth);

  desc_t                desc_q [QueueDepth];
  logic [CHAR_BITS-1:0] unit_q [QueueDepth];
  logic [PtrBits-1:0]   wr_ptr_q, rd_ptr_q;
  logic [PtrBits:0]     count_q;

  assign full_o       = (count_q == (PtrBits+1)'(QueueDepth));
  assign head_valid_o = (count_q != '0);
  assign head_desc_o  = desc_q[rd_ptr_q];
  assign head_unit_o  = unit_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (enq_i) begin
      desc_q[wr_ptr_q] <= desc_i;
      unit_q[wr_ptr_q] <= unit_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (enq_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (deq_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (enq_i && !deq_i) begin
        count_q <= count_q + 1'b1;
      end else if (deq_i && !enq_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== src/jse_back.sv =====
// Output sequencer: walks the character slots of the head item into the result register.
module jse_back #(
  parameter int unsigned CHAR_BITS = jse_pkg::CharBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 head_valid_i,
  input  jse_pkg::desc_t       head_desc_i,
  input  logic [CHAR_BITS-1:0] head_unit_i,
  output logic                 deq_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output jse_pkg::out_item_t   result_o
);
  import jse_pkg::*;

  // Slot order: opening quote, body character 0 to 5, closing quote.
  localparam logic [2:0] SLOT_QB = 3'd0;
  localparam logic [2:0] SLOT_B0 = 3'd1;
  localparam logic [2:0] SLOT_B1 = 3'd2;
  localparam logic [2:0] SLOT_H3 = 3'd3;
  localparam logic [2:0] SLOT_H2 = 3'd4;
  localparam logic [2:0] SLOT_H1 = 3'd5;
  localparam logic [2:0] SLOT_H0 = 3'd6;
  localparam logic [2:0] SLOT_QA = 3'd7;

  logic [NumSlots-1:0] done_q, slot_mask, remaining, cur_onehot;
  logic [2:0]          cur_slot;
  logic                is_last, advance, out_valid_q;
  logic [15:0]         unit_w, cur_char;
  out_item_t           out_q;

  assign unit_w = 16'(head_unit_i);

  always_comb begin
    slot_mask          = '0;
    slot_mask[SLOT_QB] = head_desc_i.quote_before;
    slot_mask[SLOT_B0] = (head_desc_i.kind != KIND_NONE);
    slot_mask[SLOT_B1] = (head_desc_i.kind == KIND_SHORT) || (head_desc_i.kind == KIND_UNI);
    slot_mask[SLOT_H3] = (head_desc_i.kind == KIND_UNI);
    slot_mask[SLOT_H2] = (head_desc_i.kind == KIND_UNI);
    slot_mask[SLOT_H1] = (head_desc_i.kind == KIND_UNI);
    slot_mask[SLOT_H0] = (head_desc_i.kind == KIND_UNI);
    slot_mask[SLOT_QA] = head_desc_i.quote_after;
  end

  assign remaining  = slot_mask & ~done_q;
  assign cur_onehot = remaining & (~remaining + 1'b1);
  assign is_last    = ((remaining & ~cur_onehot) == '0);

  always_comb begin
    cur_slot = SLOT_QB;
    for (int i = 0; i < NumSlots; i++) begin
      if (cur_onehot[i]) begin
        cur_slot = 3'(i);
      end
    end
  end

  always_comb begin
    case (cur_slot)
      SLOT_QB: cur_char = CH_QUOTE;
      SLOT_B0: cur_char = (head_desc_i.kind == KIND_PASS) ? unit_w : CH_BSLASH;
      SLOT_B1: cur_char = (head_desc_i.kind == KIND_SHORT) ? unit_w : CH_U;
      SLOT_H3: cur_char = hex_char(unit_w[15:12]);
      SLOT_H2: cur_char = hex_char(unit_w[11:8]);
      SLOT_H1: cur_char = hex_char(unit_w[7:4]);
      SLOT_H0: cur_char = hex_char(unit_w[3:0]);
      SLOT_QA: cur_char = CH_QUOTE;
      default: cur_char = CH_QUOTE;
    endcase
  end

  assign advance  = head_valid_i && (!out_valid_q || pop_i);
  assign deq_o    = advance && is_last;
  assign empty_o  = !out_valid_q;
  assign result_o = out_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q.out_char <= cur_char;
      out_q.run_end  <= is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
        done_q      <= is_last ? '0 : (done_q | cur_onehot);
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// ===== src/json_string_escaper_top.sv =====
// Top level of the JSON string escaper: front end, item queue and output sequencer.
//
// Each transaction on the input carries one code unit; the block emits its JSON-escaped
// characters one per transaction on the result side, with run_end on the last one of each
// unit. A unit that passes through gives one character, a short escape two, a \uXXXX escape
// six, and each quote one more. While pop is high, the output sequencer emits one character
// per cycle, and plain text one unit; the input stays open during escape runs until the
// four-entry item queue fills. The quoting register is sampled when a unit is accepted.
module json_string_escaper_top #(
  parameter int unsigned CHAR_BITS = jse_pkg::CharBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic               push,
  output logic               full,
  input  jse_pkg::in_item_t  in_item_i,
  output logic               empty,
  input  logic               pop,
  output jse_pkg::out_item_t result_o
);
  import jse_pkg::*;

  logic                 accept, enq, deq, head_valid;
  desc_t                desc, head_desc;
  logic [CHAR_BITS-1:0] unit, head_unit;

  assign accept = push && !full;

  jse_front #(.CHAR_BITS(CHAR_BITS)) u_front (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .accept_i (accept),
    .item_i   (in_item_i),
    .enq_o    (enq),
    .desc_o   (desc),
    .unit_o   (unit)
  );

  jse_queue #(.CHAR_BITS(CHAR_BITS)) u_queue (
    .clk_i,
    .rst_ni,
    .enq_i        (enq),
    .desc_i       (desc),
    .unit_i       (unit),
    .deq_i        (deq),
    .full_o       (full),
    .head_valid_o (head_valid),
    .head_desc_o  (head_desc),
    .head_unit_o  (head_unit)
  );

  jse_back #(.CHAR_BITS(CHAR_BITS)) u_back (
    .clk_i,
    .rst_ni,
    .head_valid_i (head_valid),
    .head_desc_i  (head_desc),
    .head_unit_i  (head_unit),
    .deq_o        (deq),
    .pop_i        (pop),
    .empty_o      (empty),
    .result_o
  );

endmodule

// ===== src/jse_checker.sv =====
// Port-level checker for the JSON string escaper and its bind to the top level.
module jse_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               empty,
  input logic               pop,
  input jse_pkg::out_item_t result_o
);
  import jse_pkg::*;

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty)
    else $error("result withdrawn before it was popped");

  a_result_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> $stable(result_o))
    else $error("waiting result changed before it was popped");

  a_result_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> !$isunknown(result_o))
    else $error("waiting result has unknown bits");

  // Units above 0xFF are always written as \u escapes, so no output exceeds 8 bits.
  a_narrow_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (result_o.out_char[15:8] == 8'h00))
    else $error("output character wider than 8 bits");

endmodule

bind json_string_escaper_top jse_checker u_jse_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .empty    (empty),
  .pop      (pop),
  .result_o (result_o)
);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// Testbench for the JSON string escaper: queued code units, an escape predictor and a checker.
module testbench;
  import jse_pkg::*;

  localparam int unsigned StallLimit   = 500;
  localparam int unsigned SettleCycles = 40;

  localparam logic [15:0] CH_SLASH     = 16'h002F;
  localparam logic [15:0] CH_BACKSPACE = 16'h0008;
  localparam logic [15:0] CH_FORMFEED  = 16'h000C;
  localparam logic [15:0] CH_NEWLINE   = 16'h000A;
  localparam logic [15:0] CH_RETURN    = 16'h000D;
  localparam logic [15:0] CH_TAB       = 16'h0009;
  localparam logic [15:0] LET_B        = 16'h0062;
  localparam logic [15:0] LET_F        = 16'h0066;
  localparam logic [15:0] LET_N        = 16'h006E;
  localparam logic [15:0] LET_R        = 16'h0072;
  localparam logic [15:0] LET_T        = 16'h0074;
  localparam logic [15:0] CTRL_LIMIT   = 16'h0020;
  localparam logic [15:0] LATIN_LIMIT  = 16'h00FF;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      cfg_we_i    = 1'b0;
  logic      cfg_wdata_i = 1'b0;
  logic      push        = 1'b0;
  logic      full;
  in_item_t  in_item_i   = '0;
  logic      empty;
  logic      pop         = 1'b0;
  out_item_t result_o;

  in_item_t    units_q[$];
  out_item_t   esc_chars_q[$];
  int unsigned mismatches   = 0;
  bit          quotes_on    = 1'b1;
  bit          idle_on      = 1'b1;
  int unsigned src_gap      = 0;
  int unsigned sink_gap     = 0;
  int unsigned stall_cycles = 0;

  json_string_escaper_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item_i),
    .empty      (empty),
    .pop        (pop),
    .result_o   (result_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic logic [15:0] hex_digit(logic [3:0] nib);
    if (nib < 4'd10) begin
      return 16'h0030 + 16'(nib);
    end
    return 16'h0041 + 16'(nib) - 16'd10;
  endfunction

  // Appends the escaped characters of one code unit to the expected results.
  function automatic void predict_escape(in_item_t it, bit quotes);
    out_item_t   chars[$];
    logic [15:0] u;
    logic [15:0] letter;
    u = it.code_unit;
    if (it.empty_string) begin
      if (quotes) begin
        chars.push_back('{CH_QUOTE, 1'b0});
        chars.push_back('{CH_QUOTE, 1'b0});
      end
    end else begin
      if (quotes && it.first_of_string) chars.push_back('{CH_QUOTE, 1'b0});
      case (u)
        CH_QUOTE:     letter = CH_QUOTE;
        CH_BSLASH:    letter = CH_BSLASH;
        CH_SLASH:     letter = CH_SLASH;
        CH_BACKSPACE: letter = LET_B;
        CH_FORMFEED:  letter = LET_F;
        CH_NEWLINE:   letter = LET_N;
        CH_RETURN:    letter = LET_R;
        CH_TAB:       letter = LET_T;
        default:      letter = '0;
      endcase
      if (letter != '0) begin
        chars.push_back('{CH_BSLASH, 1'b0});
        chars.push_back('{letter, 1'b0});
      end else if (u < CTRL_LIMIT || u > LATIN_LIMIT) begin
        chars.push_back('{CH_BSLASH, 1'b0});
        chars.push_back('{CH_U, 1'b0});
        chars.push_back('{hex_digit(u[15:12]), 1'b0});
        chars.push_back('{hex_digit(u[11:8]), 1'b0});
        chars.push_back('{hex_digit(u[7:4]), 1'b0});
        chars.push_back('{hex_digit(u[3:0]), 1'b0});
      end else begin
        chars.push_back('{u, 1'b0});
      end
      if (quotes && it.last_of_string) chars.push_back('{CH_QUOTE, 1'b0});
    end
    if (chars.size() > 0) chars[chars.size() - 1].run_end = 1'b1;
    foreach (chars[k]) esc_chars_q.push_back(chars[k]);
  endfunction

  function automatic logic [15:0] random_unit();
    logic [15:0] short_set[8];
    short_set = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_BACKSPACE,
                  CH_FORMFEED, CH_NEWLINE, CH_RETURN, CH_TAB};
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 16'($urandom_range(CTRL_LIMIT, LATIN_LIMIT));
      5:             return 16'($urandom_range(0, CTRL_LIMIT - 1));
      6:             return short_set[$urandom_range(0, 7)];
      7, 8:          return 16'($urandom_range(LATIN_LIMIT + 1, 16'hFFFF));
      default:       return 16'($urandom());
    endcase
  endfunction

  task automatic queue_unit(logic [15:0] code, bit first, bit last, bit is_empty);
    in_item_t it;
    it.code_unit       = code;
    it.first_of_string = first;
    it.last_of_string  = last;
    it.empty_string    = is_empty;
    units_q.push_back(it);
  endtask

  // Mostly well-formed strings with random content, some empty strings and some noise.
  task automatic random_strings(int unsigned n);
    int unsigned done;
    int unsigned len;
    done = 0;
    @(negedge clk_i);
    while (done < n) begin
      case ($urandom_range(0, 19))
        0: begin
          queue_unit(16'($urandom()), 1'($urandom()), 1'($urandom()), 1'b1);
          done++;
        end
        1, 2: begin
          queue_unit(16'($urandom()), 1'($urandom()), 1'($urandom()), 1'b0);
          done++;
        end
        default: begin
          len = $urandom_range(1, 6);
          for (int unsigned k = 0; k < len; k++) begin
            queue_unit(random_unit(), k == 0, k == len - 1, 1'b0);
          end
          done += len;
        end
      endcase
    end
  endtask

  // Waits until every transaction has drained, then lets an item with no result finish.
  task automatic settle();
    do begin
      while (units_q.size() != 0 || esc_chars_q.size() != 0) @(posedge clk_i);
      repeat (SettleCycles) @(posedge clk_i);
    end while (units_q.size() != 0 || esc_chars_q.size() != 0);
  endtask

  task automatic write_quotes(bit value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    quotes_on = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin : driver
    bit taken;
    taken = push && !full;
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (taken) void'(units_q.pop_front());
      if (push && !taken) begin
        // The current item stays on the port until it is accepted.
      end else if (src_gap > 0) begin
        src_gap = src_gap - 1;
        push <= 1'b0;
      end else if (idle_on && units_q.size() > 0 && $urandom_range(0, 9) == 0) begin
        src_gap = $urandom_range(1, 13) - 1;
        push <= 1'b0;
      end else if (units_q.size() > 0) begin
        push      <= 1'b1;
        in_item_i <= units_q[0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : sink
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap = sink_gap - 1;
      pop <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      sink_gap = $urandom_range(1, 13) - 1;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : monitor
    out_item_t want;
    if (rst_ni) begin
      if (push && !full) predict_escape(in_item_i, quotes_on);
      if (pop && !empty) begin
        if (esc_chars_q.size() == 0) begin
          $error("unexpected result: out_char %h run_end %b",
                 result_o.out_char, result_o.run_end);
          mismatches++;
        end else begin
          want = esc_chars_q.pop_front();
          if (result_o.out_char !== want.out_char) begin
            $error("out_char: expected %h, actual %h", want.out_char, result_o.out_char);
            mismatches++;
          end
          if (result_o.run_end !== want.run_end) begin
            $error("run_end: expected %b, actual %b", want.run_end, result_o.run_end);
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((push && !full) || (pop && !empty) ||
        (units_q.size() == 0 && esc_chars_q.size() == 0)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Quoting is on out of reset.
    @(negedge clk_i);
    queue_unit(16'hFFFF, 1'b1, 1'b1, 1'b1);
    queue_unit(16'h0041, 1'b1, 1'b1, 1'b0);
    queue_unit(CH_QUOTE, 1'b1, 1'b0, 1'b0);
    queue_unit(CH_BSLASH, 1'b0, 1'b0, 1'b0);
    queue_unit(CH_SLASH, 1'b0, 1'b1, 1'b0);
    queue_unit(CH_BACKSPACE, 1'b1, 1'b0, 1'b0);
    queue_unit(CH_FORMFEED, 1'b0, 1'b0, 1'b0);
    queue_unit(CH_NEWLINE, 1'b0, 1'b0, 1'b0);
    queue_unit(CH_RETURN, 1'b0, 1'b0, 1'b0);
    queue_unit(CH_TAB, 1'b0, 1'b1, 1'b0);
    queue_unit(16'h0000, 1'b1, 1'b0, 1'b0);
    queue_unit(16'h001F, 1'b0, 1'b0, 1'b0);
    queue_unit(16'h0020, 1'b0, 1'b0, 1'b0);
    queue_unit(16'h00FF, 1'b0, 1'b0, 1'b0);
    queue_unit(16'h0100, 1'b0, 1'b0, 1'b0);
    queue_unit(16'hFFFF, 1'b0, 1'b1, 1'b0);
    // Marks out of order: no first, a lone last, and two firsts in a row.
    queue_unit(16'h0061, 1'b0, 1'b0, 1'b0);
    queue_unit(16'h0062, 1'b0, 1'b1, 1'b0);
    queue_unit(16'h0063, 1'b1, 1'b0, 1'b0);
    queue_unit(16'h0064, 1'b1, 1'b0, 1'b0);
    settle();

    write_quotes(1'b0);
    @(negedge clk_i);
    queue_unit(16'h0000, 1'b0, 1'b0, 1'b1);
    queue_unit(CH_QUOTE, 1'b1, 1'b1, 1'b0);
    queue_unit(16'hABCD, 1'b1, 1'b0, 1'b0);
    queue_unit(16'h0041, 1'b0, 1'b1, 1'b0);
    random_strings(48);
    settle();

    write_quotes(1'b1);
    random_strings(48);
    settle();

    write_quotes(1'b0);
    random_strings(48);
    settle();

    write_quotes(1'b1);
    idle_on = 1'b0;
    random_strings(48);
    settle();

    if (mismatches == 0 && esc_chars_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
